[hw/rtl/teq_pkg.sv]
// Shared types and constants of the timer expiry queue.
package teq_pkg;

    localparam int OP_W   = 2;
    localparam int SLOT_W = 4;
    localparam int TIME_W = 64;
    localparam int KIND_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_UPDATE = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EVENT  = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED   = 2'd0,
        KIND_PROGRAM = 2'd1,
        KIND_DISARM  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_FIRE,
        ST_SCAN,
        ST_RESULT
    } t_state;

endpackage

[hw/rtl/teq_in_if.sv]
// Request channel of the timer expiry queue: one operation word per handshake.
interface teq_in_if
    import teq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] expiry_time;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, operation, slot, expiry_time, now_time, input ready);
    modport sink   (input valid, operation, slot, expiry_time, now_time, output ready);
endinterface

[hw/rtl/teq_out_if.sv]
// Result channel of the timer expiry queue: one fired or compare word per handshake.
interface teq_out_if
    import teq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] fired_slot;
    logic [TIME_W-1:0] compare_time;
    logic              last;

    modport source (output valid, kind, fired_slot, compare_time, last, input ready);
    modport sink   (input valid, kind, fired_slot, compare_time, last, output ready);
endinterface

[hw/rtl/timer_expiry_queue_core.sv]
// Timer expiry queue: expiry memory, registered bits and the scanning sequencer.
//
// Holds NUM_TIMERS timer slots; expiries live in a single-port synchronous memory
// and the registered bits in flip-flops. One request word is taken at a time.
// Ignored requests return to idle with no word; an add or update that programs
// its own expiry while the compare event is disarmed loads its compare word
// directly and waits only for the output. Every other request runs a minimum
// search that reads the memory once per slot, then emits the word. A clock event
// that fires k timers runs k + 1 such searches through the one read port of the
// expiry memory. The result register lets the sequencer run on while a word waits
// to be taken.
module timer_expiry_queue_core
    import teq_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    teq_in_if.sink          i_item,
    teq_out_if.source       o_result
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    logic [TIME_W-1:0] r_mem [NUM_TIMERS];

    t_state            r_state, n_state;
    logic [NUM_TIMERS-1:0] r_reg;
    logic              r_event_active;

    t_op               r_op;
    logic [SLOT_W-1:0] r_slot;
    logic [TIME_W-1:0] r_exp;
    logic [TIME_W-1:0] r_now;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [TIME_W-1:0] r_rd_data;
    logic              r_best_found;
    logic [TIME_W-1:0] r_best_time;
    logic [IDX_W-1:0]  r_best_idx;

    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [SLOT_W-1:0] r_out_slot;
    logic [TIME_W-1:0] r_out_time;
    logic              r_out_last;

    logic              out_free;
    logic              slot_ok;
    logic [IDX_W-1:0]  slot_idx;
    logic              slot_reg;
    logic              is_late;
    logic              ignore;
    logic              fire_now;
    logic              scan_issue;
    logic              scan_done;
    logic              best_take;

    logic              c_mem_wr;
    logic              c_set_slot;
    logic              c_clr_slot;
    logic              c_clr_best;
    logic              c_start_scan;
    logic              c_load_direct;
    logic              c_load_out;
    t_kind             c_out_kind;
    logic [SLOT_W-1:0] c_out_slot;
    logic [TIME_W-1:0] c_out_time;
    logic              c_out_last;
    logic              c_upd_active;
    logic              c_active_val;

    assign out_free   = !r_out_valid || o_result.ready;
    assign slot_ok    = (32'(r_slot) < NUM_TIMERS);
    assign slot_idx   = IDX_W'(r_slot);
    assign slot_reg   = r_reg[slot_idx];
    assign is_late    = (r_exp < r_now);
    assign fire_now   = r_best_found && (r_best_time <= r_now);
    assign scan_issue = (r_state == ST_SCAN) && (r_cnt != CNT_W'(NUM_TIMERS));
    assign scan_done  = (r_state == ST_SCAN) && (r_cnt == CNT_W'(NUM_TIMERS)) && !r_rd_vld;
    assign best_take  = r_rd_vld && r_reg[r_rd_idx] &&
                        (!r_best_found || (r_rd_data < r_best_time));

    always_comb begin
        case (r_op)
            OP_ADD:    ignore = !slot_ok || slot_reg;
            OP_UPDATE: ignore = !slot_ok || !slot_reg;
            OP_REMOVE: ignore = !slot_ok || !slot_reg;
            default:   ignore = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_item.valid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_op == OP_EVENT) begin
                    n_state = ST_SCAN;
                end else if (ignore) begin
                    n_state = ST_IDLE;
                end else if (r_op == OP_REMOVE) begin
                    n_state = ST_SCAN;
                end else if (is_late) begin
                    n_state = ST_FIRE;
                end else if (!r_event_active) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_FIRE: begin
                if (out_free) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_done) n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ((r_op == OP_EVENT) && fire_now) ? ST_SCAN : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control strobes
    always_comb begin
        c_mem_wr      = 1'b0;
        c_set_slot    = 1'b0;
        c_clr_slot    = 1'b0;
        c_clr_best    = 1'b0;
        c_load_direct = 1'b0;
        c_load_out    = 1'b0;
        c_out_kind    = KIND_DISARM;
        c_out_slot    = '0;
        c_out_time    = '0;
        c_out_last    = 1'b0;
        c_upd_active  = 1'b0;
        c_active_val  = 1'b0;
        c_start_scan  = (n_state == ST_SCAN) && (r_state != ST_SCAN);
        case (r_state)
            ST_DECIDE: begin
                if (r_op != OP_EVENT && !ignore) begin
                    if (r_op == OP_REMOVE) begin
                        c_clr_slot = 1'b1;
                    end else begin
                        c_mem_wr = 1'b1;
                        if (is_late) begin
                            c_clr_slot = 1'b1;
                        end else begin
                            c_set_slot    = 1'b1;
                            c_load_direct = !r_event_active;
                        end
                    end
                end
            end
            ST_FIRE: begin
                c_load_out = out_free;
                c_out_kind = KIND_FIRED;
                c_out_slot = r_slot;
            end
            ST_RESULT: begin
                c_load_out = out_free;
                if ((r_op == OP_EVENT) && fire_now) begin
                    c_out_kind = KIND_FIRED;
                    c_out_slot = SLOT_W'(r_best_idx);
                    c_clr_best = out_free;
                end else begin
                    // zero time means disarm
                    c_upd_active = out_free;
                    c_out_last   = 1'b1;
                    if (r_best_found && (r_best_time != '0)) begin
                        c_out_kind   = KIND_PROGRAM;
                        c_out_time   = r_best_time;
                        c_active_val = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_reg          <= '0;
            r_event_active <= 1'b0;
            r_out_valid    <= 1'b0;
            r_rd_vld       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c_set_slot) r_reg[slot_idx] <= 1'b1;
            if (c_clr_slot) r_reg[slot_idx] <= 1'b0;
            if (c_clr_best) r_reg[r_best_idx] <= 1'b0;
            if (c_upd_active) r_event_active <= c_active_val;
            if (c_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            r_rd_vld <= scan_issue;
        end
    end

    // Request word, scan datapath and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_item.valid) begin
            r_op   <= t_op'(i_item.operation);
            r_slot <= i_item.slot;
            r_exp  <= i_item.expiry_time;
            r_now  <= i_item.now_time;
        end
        if (c_start_scan) begin
            r_cnt        <= '0;
            r_best_found <= 1'b0;
        end else begin
            if (scan_issue) r_cnt <= r_cnt + 1'b1;
            if (best_take) begin
                r_best_found <= 1'b1;
                r_best_time  <= r_rd_data;
                r_best_idx   <= r_rd_idx;
            end
        end
        if (c_load_direct) begin
            r_best_found <= 1'b1;
            r_best_time  <= r_exp;
        end
        r_rd_idx <= r_cnt[IDX_W-1:0];
        if (c_load_out) begin
            r_out_kind <= c_out_kind;
            r_out_slot <= c_out_slot;
            r_out_time <= c_out_time;
            r_out_last <= c_out_last;
        end
    end

    // Expiry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (c_mem_wr) r_mem[slot_idx] <= r_exp;
        if (scan_issue) r_rd_data <= r_mem[r_cnt[IDX_W-1:0]];
    end

    assign i_item.ready          = (r_state == ST_IDLE);
    assign o_result.valid        = r_out_valid;
    assign o_result.kind         = r_out_kind;
    assign o_result.fired_slot   = r_out_slot;
    assign o_result.compare_time = r_out_time;
    assign o_result.last         = r_out_last;

`ifndef SYNTH
    a_fire_registered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_clr_best |-> r_reg[r_best_idx])
        else $error("fired slot was not registered");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_SCAN))
        else $error("memory read data outside a scan");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_load_out && c_out_last) |=> (r_state == ST_IDLE))
        else $error("final word did not end the item");

    a_program_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_upd_active && (c_out_kind == KIND_PROGRAM)) |=> r_event_active)
        else $error("programmed compare left the event disarmed");
`endif

endmodule
